// ===== design/gradient_edge_nms_filter_core_defines.svh =====
// Assertion macros for the gradient edge filter.
`ifndef GRADIENT_EDGE_NMS_FILTER_CORE_DEFINES_SVH
`define GRADIENT_EDGE_NMS_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GENF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GENF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/genf_pkg.sv =====
package genf_pkg;

  localparam int ROW_W      = 13;
  localparam int IDX_W      = 15;
  localparam int ACC_W      = 16;
  localparam int GRD_W      = 14;
  localparam int ABS_W      = 12;
  localparam int SQ_W       = 24;
  localparam int NSUM_W     = 25;
  localparam int SSQ_W      = 26;
  localparam int PIX_W      = 8;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WREG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS     = 2'd2;

  localparam logic [DIR_W-1:0] DIR_HORZ      = 2'd0;
  localparam logic [DIR_W-1:0] DIR_VERT      = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DIAG_OPP  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_DIAG_SAME = 2'd3;

  localparam logic [ROW_W-1:0]  HEIGHT_MIN  = 13'd8;
  localparam logic [ROW_W-1:0]  HEIGHT_MAX  = 13'd4096;
  localparam logic [WREG_W-1:0] WIDTH_MIN   = 11'd8;
  localparam logic [ROW_W-1:0]  HEIGHT_RST  = 13'd480;
  localparam logic [WREG_W-1:0] WIDTH_RST   = 11'd640;
  localparam logic [NSUM_W-1:0] SQRT_LIMIT  = 25'd65536;

  // line store regions in the shared memory (upper address bits)
  localparam logic [1:0] REG_BLUR = 2'b10;
  localparam logic [1:0] REG_MAG  = 2'b11;

  typedef logic signed [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic pix_tick;
    logic frame_end;
    logic b_ok;
    logic m_ok;
    logic o_ok;
    logic eor;
    logic eof;
  } tick_flags_t;

  function automatic idx_t reflect101(idx_t v, idx_t n);
    idx_t x;
    x = (v < 0) ? -v : v;
    if (x >= n) x = (n <<< 1) - 15'sd2 - x;
    return x;
  endfunction

  function automatic idx_t clamp_idx(idx_t v, idx_t n);
    idx_t x;
    x = v;
    if (v < 0) x = '0;
    else if (v >= n) x = n - 15'sd1;
    return x;
  endfunction

  function automatic logic [2:0] binom5(logic [2:0] i);
    logic [2:0] b;
    unique case (i)
      3'd0, 3'd4: b = 3'd1;
      3'd1, 3'd3: b = 3'd4;
      3'd2:       b = 3'd6;
      default:    b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] binom_w(logic [2:0] i, logic [2:0] j);
    return 6'(binom5(i)) * 6'(binom5(j));
  endfunction

  function automatic logic signed [4:0] scharr_kx(logic [2:0] i, logic [2:0] j);
    logic signed [4:0] w;
    logic signed [4:0] k;
    w = (i == 3'd1) ? 5'sd10 : 5'sd3;
    unique case (j)
      3'd0:    k = -w;
      3'd2:    k = w;
      default: k = 5'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [4:0] scharr_ky(logic [2:0] i, logic [2:0] j);
    return scharr_kx(j, i);
  endfunction

  function automatic logic signed [1:0] nb_dy(logic [DIR_W-1:0] d, logic k);
    logic signed [1:0] y;
    unique case (d)
      DIR_HORZ:     y = 2'sd0;
      DIR_VERT:     y = k ? -2'sd1 : 2'sd1;
      DIR_DIAG_OPP: y = k ? 2'sd1 : -2'sd1;
      default:      y = k ? -2'sd1 : 2'sd1;
    endcase
    return y;
  endfunction

  function automatic logic signed [1:0] nb_dx(logic [DIR_W-1:0] d, logic k);
    logic signed [1:0] x;
    unique case (d)
      DIR_HORZ:     x = k ? -2'sd1 : 2'sd1;
      DIR_VERT:     x = 2'sd0;
      DIR_DIAG_OPP: x = k ? -2'sd1 : 2'sd1;
      default:      x = k ? -2'sd1 : 2'sd1;
    endcase
    return x;
  endfunction

endpackage

// ===== design/genf_ram.sv =====
module genf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/genf_tick.sv =====
module genf_tick #(
  parameter int CW = 10,
  parameter int WW = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         adv,
  input  logic [WW-1:0]                w_used,
  input  logic [genf_pkg::ROW_W-1:0]   h_used,
  output logic [CW-1:0]                col,
  output logic [2:0]                   row_lo,
  output genf_pkg::idx_t               pos_row [3],
  output genf_pkg::idx_t               pos_col [3],
  output genf_pkg::tick_flags_t        flags
);
  import genf_pkg::*;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             pos_ok [3];
  idx_t             w_idx, h_idx;

  assign w_idx  = idx_t'(w_used);
  assign h_idx  = idx_t'(h_used);
  assign col    = col_r;
  assign row_lo = row_r[2:0];

  // blur, gradient and output positions trail the tick by k*(W+1), k = 2, 3, 4
  for (genvar g = 0; g < 3; g++) begin : g_pos
    localparam int K = g + 2;
    always_comb begin
      if (idx_t'(col_r) >= idx_t'(K)) begin
        pos_col[g] = idx_t'(col_r) - idx_t'(K);
        pos_row[g] = idx_t'(row_r) - idx_t'(K);
      end else begin
        pos_col[g] = idx_t'(col_r) + w_idx - idx_t'(K);
        pos_row[g] = idx_t'(row_r) - idx_t'(K) - 15'sd1;
      end
      pos_ok[g] = (pos_row[g] >= 0) && (pos_row[g] < h_idx);
    end
  end

  always_comb begin
    flags.pix_tick  = row_r < h_used;
    flags.frame_end = (row_r == h_used + 13'd4) && (col_r == CW'(3));
    flags.b_ok      = pos_ok[0];
    flags.m_ok      = pos_ok[1];
    flags.o_ok      = pos_ok[2];
    flags.eor       = pos_col[2] == w_idx - 15'sd1;
    flags.eof       = flags.eor && (pos_row[2] == h_idx - 15'sd1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (flags.frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (WW'(col_r) + WW'(1) == w_used) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== design/gradient_edge_nms_filter_core.sv =====
// Canny-style edge strength: 5x5 binomial blur, 3x3 Scharr gradient, magnitude
// floor(sqrt(dx^2+dy^2)) saturated to 255 and optional non-maximum suppression
// over four direction sectors. Pixels stream in raster order; the result for
// pixel k comes out on input beat k + 4*W + 4, so 4*W + 4 drain beats flush a
// frame. All line stores share one memory with a single read port, and every
// beat walks through its reads in turn: a full beat has 25 blur reads, 9
// gradient reads, 8 square root steps, 3 suppression reads and the writes
// between them, fewer at frame edges where a stage has nothing to do.
// A drain beat during the pixel part of a frame is accepted and dropped.
// Writing frame width or height restarts the frame.
`include "gradient_edge_nms_filter_core_defines.svh"

module gradient_edge_nms_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] pixel_value
  input  logic                             in_tuser,   // [0] is_drain
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] edge_value
  output logic                             out_tlast,  // end_of_row
  output logic                             out_tuser,  // [0] end_of_frame
  input  logic                             cfg_we,
  input  logic [genf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [genf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import genf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int AW = CW + 4;
  localparam int MW = PIX_W + DIR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BLUR = 4'd1;
  localparam logic [3:0] S_BWR  = 4'd2;
  localparam logic [3:0] S_GRAD = 4'd3;
  localparam logic [3:0] S_GSQ1 = 4'd4;
  localparam logic [3:0] S_GSQ2 = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_GWR  = 4'd7;
  localparam logic [3:0] S_NMS  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // configuration
  logic [WREG_W-1:0] width_r;
  logic [ROW_W-1:0]  height_r;
  logic              supp_r;
  logic [31:0]       w32;
  logic [WW-1:0]     w_used;
  logic [ROW_W-1:0]  h_used;
  idx_t              w_idx, h_idx;
  logic              size_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      supp_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_WIDTH:  width_r  <= cfg_data[WREG_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_data;
        CFG_SUPPRESS:     supp_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign size_wr = cfg_we && ((cfg_addr == CFG_FRAME_WIDTH) || (cfg_addr == CFG_FRAME_HEIGHT));

  always_comb begin
    if (width_r < WIDTH_MIN) w32 = 32'(WIDTH_MIN);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    else w32 = 32'(width_r);
    if (height_r < HEIGHT_MIN) h_used = HEIGHT_MIN;
    else if (height_r > HEIGHT_MAX) h_used = HEIGHT_MAX;
    else h_used = height_r;
  end

  assign w_used = w32[WW-1:0];
  assign w_idx  = idx_t'(w_used);
  assign h_idx  = idx_t'(h_used);

  // frame tick
  logic [CW-1:0] t_col;
  logic [2:0]    t_row_lo;
  idx_t          pos_row [3];
  idx_t          pos_col [3];
  tick_flags_t   flags;
  logic          in_acc, adv;

  assign in_acc = in_tvalid && in_tready;
  assign adv    = in_acc && !(flags.pix_tick && in_tuser);

  genf_tick #(.CW(CW), .WW(WW)) u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (size_wr),
    .adv     (adv),
    .w_used  (w_used),
    .h_used  (h_used),
    .col     (t_col),
    .row_lo  (t_row_lo),
    .pos_row (pos_row),
    .pos_col (pos_col),
    .flags   (flags)
  );

  // line store memory: raw rows 0..7, blur rows 8..11, magnitude rows 12..15
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  genf_ram #(.WIDTH(MW), .DEPTH(16 * (2 ** CW))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  logic [3:0]        state_r, state_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [2:0]        ri_r, ri_nxt, rj_r, rj_nxt, ai_r, ai_nxt, aj_r, aj_nxt;
  idx_t              by_r, bx_r, my_r, mx_r, oy_r, ox_r;
  logic              m_ok_r, o_ok_r, eor_r, eof_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [GRD_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, px_prod, py_prod;
  logic [ABS_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, ax_c, ay_c, diff_c;
  logic [SQ_W-1:0]   ax2_r, ax2_nxt, ay2_r, ay2_nxt, diff2_r, diff2_nxt;
  logic [NSUM_W-1:0] n_r, n_nxt;
  logic [SSQ_W-1:0]  sum2_r, sum2_nxt;
  logic [ABS_W:0]    sum_c;
  logic [DIR_W-1:0]  dir_r, dir_nxt, dir_c, cd_r, cd_nxt, nb_d;
  logic [PIX_W-1:0]  root_r, root_nxt, cand_c, v_r, v_nxt, res_r, res_nxt, blur_c, mag_c;
  logic [15:0]       cand_sq;
  logic [2:0]        bit_r, bit_nxt;
  logic              nv0_r, nv0_nxt, nv1_r, nv1_nxt, sup0_r, sup0_nxt, sup1_c, nb_k, nb_in;
  idx_t              brow, bcol, grow, gcol, nb_y, nb_x;
  logic              out_tvalid_r, out_tvalid_nxt, out_tlast_r, out_tlast_nxt;
  logic              out_tuser_r, out_tuser_nxt;
  logic [PIX_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic              out_free;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    brow    = reflect101(by_r + idx_t'(ri_r) - 15'sd2, h_idx);
    bcol    = reflect101(bx_r + idx_t'(rj_r) - 15'sd2, w_idx);
    grow    = clamp_idx(my_r + idx_t'(ri_r) - 15'sd1, h_idx);
    gcol    = clamp_idx(mx_r + idx_t'(rj_r) - 15'sd1, w_idx);
    px_prod = $signed({1'b0, ram_rdata[PIX_W-1:0]}) * scharr_kx(ai_r, aj_r);
    py_prod = $signed({1'b0, ram_rdata[PIX_W-1:0]}) * scharr_ky(ai_r, aj_r);
    ax_c    = ABS_W'((dx_r < 0) ? -dx_r : dx_r);
    ay_c    = ABS_W'((dy_r < 0) ? -dy_r : dy_r);
    sum_c   = {1'b0, ax_r} + {1'b0, ay_r};
    diff_c  = (ay_r > ax_r) ? ay_r - ax_r : '0;
    cand_c  = root_r | (8'd1 << bit_r);
    cand_sq = 16'(cand_c) * 16'(cand_c);
    blur_c  = PIX_W'((acc_r + 16'd128) >> 8);
    mag_c   = (n_r >= SQRT_LIMIT) ? 8'd255 : root_r;
    nb_d    = (cnt_r == 5'd1) ? ram_rdata[MW-1:PIX_W] : cd_r;
    nb_k    = cnt_r != 5'd1;
    nb_y    = oy_r + idx_t'(nb_dy(nb_d, nb_k));
    nb_x    = ox_r + idx_t'(nb_dx(nb_d, nb_k));
    nb_in   = (nb_y >= 0) && (nb_y < h_idx) && (nb_x >= 0) && (nb_x < w_idx);
    sup1_c  = nv1_r && (v_r < ram_rdata[PIX_W-1:0]);
    if (ay_r == '0) dir_c = DIR_HORZ;
    else if (sum2_r < {1'b0, ax2_r, 1'b0}) dir_c = DIR_HORZ;
    else if ((ay_r > ax_r) && ({1'b0, diff2_r} > {ax2_r, 1'b0})) dir_c = DIR_VERT;
    else if ((dx_r < 0) == (dy_r < 0)) dir_c = DIR_DIAG_SAME;
    else dir_c = DIR_DIAG_OPP;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 5'd1;
    ri_nxt    = ri_r;
    rj_nxt    = rj_r;
    ai_nxt    = ri_r;
    aj_nxt    = rj_r;
    acc_nxt   = acc_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    ax2_nxt   = ax2_r;
    ay2_nxt   = ay2_r;
    n_nxt     = n_r;
    sum2_nxt  = sum2_r;
    diff2_nxt = diff2_r;
    dir_nxt   = dir_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    v_nxt     = v_r;
    cd_nxt    = cd_r;
    nv0_nxt   = nv0_r;
    nv1_nxt   = nv1_r;
    sup0_nxt  = sup0_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = {1'b0, t_row_lo, t_col};
    ram_wdata = {2'b00, in_tdata};
    ram_raddr = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;

    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        ri_nxt  = '0;
        rj_nxt  = '0;
        acc_nxt = '0;
        dx_nxt  = '0;
        dy_nxt  = '0;
        if (adv) begin
          ram_we = flags.pix_tick;
          priority if (flags.b_ok) state_nxt = S_BLUR;
          else if (flags.m_ok) state_nxt = S_GRAD;
          else if (flags.o_ok) state_nxt = S_NMS;
          else state_nxt = S_IDLE;
        end
      end
      S_BLUR: begin
        ram_raddr = {1'b0, brow[2:0], bcol[CW-1:0]};
        rj_nxt    = (rj_r == 3'd4) ? 3'd0 : rj_r + 3'd1;
        ri_nxt    = (rj_r == 3'd4) ? ri_r + 3'd1 : ri_r;
        if (cnt_r != 5'd0) begin
          acc_nxt = acc_r + 16'(ram_rdata[PIX_W-1:0]) * 16'(binom_w(ai_r, aj_r));
        end
        if (cnt_r == 5'd25) state_nxt = S_BWR;
      end
      S_BWR: begin
        ram_we    = 1'b1;
        ram_waddr = {REG_BLUR, by_r[1:0], bx_r[CW-1:0]};
        ram_wdata = {2'b00, blur_c};
        cnt_nxt   = '0;
        ri_nxt    = '0;
        rj_nxt    = '0;
        priority if (m_ok_r) state_nxt = S_GRAD;
        else if (o_ok_r) state_nxt = S_NMS;
        else state_nxt = S_IDLE;
      end
      S_GRAD: begin
        ram_raddr = {REG_BLUR, grow[1:0], gcol[CW-1:0]};
        rj_nxt    = (rj_r == 3'd2) ? 3'd0 : rj_r + 3'd1;
        ri_nxt    = (rj_r == 3'd2) ? ri_r + 3'd1 : ri_r;
        if (cnt_r != 5'd0) begin
          dx_nxt = dx_r + px_prod;
          dy_nxt = dy_r + py_prod;
        end
        if (cnt_r == 5'd9) state_nxt = S_GSQ1;
      end
      S_GSQ1: begin
        ax_nxt    = ax_c;
        ay_nxt    = ay_c;
        ax2_nxt   = SQ_W'(ax_c) * SQ_W'(ax_c);
        ay2_nxt   = SQ_W'(ay_c) * SQ_W'(ay_c);
        state_nxt = S_GSQ2;
      end
      S_GSQ2: begin
        n_nxt     = NSUM_W'(ax2_r) + NSUM_W'(ay2_r);
        sum2_nxt  = SSQ_W'(sum_c) * SSQ_W'(sum_c);
        diff2_nxt = SQ_W'(diff_c) * SQ_W'(diff_c);
        root_nxt  = '0;
        bit_nxt   = 3'd7;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        dir_nxt = dir_c;
        if (NSUM_W'(cand_sq) <= n_r) root_nxt = cand_c;
        bit_nxt = bit_r - 3'd1;
        if (bit_r == 3'd0) state_nxt = S_GWR;
      end
      S_GWR: begin
        ram_we    = 1'b1;
        ram_waddr = {REG_MAG, my_r[1:0], mx_r[CW-1:0]};
        ram_wdata = {dir_r, mag_c};
        cnt_nxt   = '0;
        state_nxt = o_ok_r ? S_NMS : S_IDLE;
      end
      S_NMS: begin
        unique case (cnt_r)
          5'd0: begin
            ram_raddr = {REG_MAG, oy_r[1:0], ox_r[CW-1:0]};
          end
          5'd1: begin
            v_nxt     = ram_rdata[PIX_W-1:0];
            cd_nxt    = ram_rdata[MW-1:PIX_W];
            nv0_nxt   = nb_in;
            ram_raddr = {REG_MAG, nb_y[1:0], nb_x[CW-1:0]};
          end
          5'd2: begin
            sup0_nxt  = nv0_r && (v_r < ram_rdata[PIX_W-1:0]);
            nv1_nxt   = nb_in;
            ram_raddr = {REG_MAG, nb_y[1:0], nb_x[CW-1:0]};
          end
          default: begin
            res_nxt   = (supp_r && (sup0_r || sup1_c)) ? '0 : v_r;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          out_tlast_nxt  = eor_r;
          out_tuser_nxt  = eof_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    ri_r        <= ri_nxt;
    rj_r        <= rj_nxt;
    ai_r        <= ai_nxt;
    aj_r        <= aj_nxt;
    acc_r       <= acc_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    ax2_r       <= ax2_nxt;
    ay2_r       <= ay2_nxt;
    n_r         <= n_nxt;
    sum2_r      <= sum2_nxt;
    diff2_r     <= diff2_nxt;
    dir_r       <= dir_nxt;
    root_r      <= root_nxt;
    bit_r       <= bit_nxt;
    v_r         <= v_nxt;
    cd_r        <= cd_nxt;
    nv0_r       <= nv0_nxt;
    nv1_r       <= nv1_nxt;
    sup0_r      <= sup0_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (adv) begin
      by_r   <= pos_row[0];
      bx_r   <= pos_col[0];
      my_r   <= pos_row[1];
      mx_r   <= pos_col[1];
      oy_r   <= pos_row[2];
      ox_r   <= pos_col[2];
      m_ok_r <= flags.m_ok;
      o_ok_r <= flags.o_ok;
      eor_r  <= flags.eor;
      eof_r  <= flags.eof;
    end
  end

  `GENF_ASSERT_IMPL(a_eof_has_eor, out_tvalid && out_tuser, out_tlast, "frame end without row end")
  `GENF_ASSERT_NEXT(a_out_loaded, (state_r == S_OUT) && (state_nxt == S_IDLE), out_tvalid, "result not loaded")
  `GENF_ASSERT_IMPL(a_col_range, 1'b1, WW'(t_col) < w_used, "tick column past row width")

endmodule

// ===== verif/tb_gradient_edge_nms_filter_core.sv =====
`timescale 1ns / 100ps

module tb_gradient_edge_nms_filter_core;
  import genf_pkg::*;

  localparam int LINE_LEN = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] pix;
    logic       drain;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] strength;
    logic       eor;
    logic       eof;
  } edge_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] pixel_value
  logic in_tuser = 1'b0;       // [0] is_drain
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;       // [7:0] edge_value
  logic out_tlast;
  logic out_tuser;             // [0] end_of_frame
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gradient_edge_nms_filter_core dut (.*);

  pix_beat_t  pix_queue[$];
  edge_beat_t edge_queue[$];
  int  n_errors = 0;
  int  n_cycles = 0;
  bit  steady = 1'b0;
  int  hold_req = 0;

  // predictor state
  logic [7:0] raw_mem [0:8*LINE_LEN-1];
  logic [7:0] blur_mem [0:4*LINE_LEN-1];
  logic [7:0] mag_mem [0:4*LINE_LEN-1];
  logic [1:0] dir_mem [0:4*LINE_LEN-1];
  int  reg_w = 640;
  int  reg_h = 480;
  bit  reg_sup = 1'b1;
  int  col_cnt = 0;
  int  row_cnt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int refl(int i, int n);
    int v;
    v = (i < 0) ? -i : i;
    if (v >= n) v = 2 * n - 2 - v;
    return v;
  endfunction

  function automatic int clip(int i, int n);
    return (i < 0) ? 0 : ((i >= n) ? n - 1 : i);
  endfunction

  function automatic void blur_px(int by, int bx, int w, int h);
    int s, i, j, ry;
    int k5 [5];
    k5 = '{1, 4, 6, 4, 1};
    s = 0;
    for (i = 0; i < 5; i++) begin
      ry = refl(by + i - 2, h) & 7;
      for (j = 0; j < 5; j++)
        s += k5[i] * k5[j] * raw_mem[ry * LINE_LEN + refl(bx + j - 2, w)];
    end
    blur_mem[(by & 3) * LINE_LEN + bx] = 8'((s + 128) >> 8);
  endfunction

  function automatic void grad_px(int my, int mx, int w, int h);
    int p [3][3];
    int i, j, ry, dx, dy, ax, ay, n, r, c, two_ax2, sm, idx;
    logic [1:0] d;
    for (i = 0; i < 3; i++) begin
      ry = clip(my + i - 1, h) & 3;
      for (j = 0; j < 3; j++)
        p[i][j] = blur_mem[ry * LINE_LEN + clip(mx + j - 1, w)];
    end
    dx = 3 * (p[0][2] - p[0][0]) + 10 * (p[1][2] - p[1][0]) + 3 * (p[2][2] - p[2][0]);
    dy = 3 * (p[2][0] - p[0][0]) + 10 * (p[2][1] - p[0][1]) + 3 * (p[2][2] - p[0][2]);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    n = ax * ax + ay * ay;
    two_ax2 = 2 * ax * ax;
    sm = ax + ay;
    if (ay == 0 || sm * sm < two_ax2) d = DIR_HORZ;
    else if (ay > ax && (ay - ax) * (ay - ax) > two_ax2) d = DIR_VERT;
    else d = ((dx < 0) == (dy < 0)) ? DIR_DIAG_SAME : DIR_DIAG_OPP;
    r = 0;
    if (n >= 65536) r = 255;
    else
      for (int b = 128; b != 0; b >>= 1) begin
        c = r + b;
        if (c * c <= n) r = c;
      end
    idx = (my & 3) * LINE_LEN + mx;
    mag_mem[idx] = 8'(r);
    dir_mem[idx] = d;
  endfunction

  function automatic logic [7:0] nms_px(int oy, int ox, int w, int h);
    int idx, ny, nx, sy, sx;
    logic [7:0] v;
    idx = (oy & 3) * LINE_LEN + ox;
    v = mag_mem[idx];
    if (!reg_sup) return v;
    case (dir_mem[idx])
      DIR_HORZ:     begin sy = 0;  sx = 1; end
      DIR_VERT:     begin sy = 1;  sx = 0; end
      DIR_DIAG_OPP: begin sy = -1; sx = 1; end
      default:      begin sy = 1;  sx = 1; end
    endcase
    for (int k = 0; k < 2; k++) begin
      ny = oy + (k ? -sy : sy);
      nx = ox + (k ? -sx : sx);
      if (ny >= 0 && ny < h && nx >= 0 && nx < w && v < mag_mem[(ny & 3) * LINE_LEN + nx])
        return 8'd0;
    end
    return v;
  endfunction

  function automatic void edge_predict(logic [7:0] pix, logic drain);
    int w, h, p, lat, t, b, m, o;
    edge_beat_t e;
    w = (reg_w < 8) ? 8 : ((reg_w > LINE_LEN) ? LINE_LEN : reg_w);
    h = (reg_h < 8) ? 8 : ((reg_h > 4096) ? 4096 : reg_h);
    p = w * h;
    lat = 4 * w + 4;
    t = row_cnt * w + col_cnt;
    if (t < p) begin
      if (drain) return;
      raw_mem[(row_cnt & 7) * LINE_LEN + col_cnt] = pix;
    end
    b = t - (2 * w + 2);
    if (b >= 0 && b < p) blur_px(b / w, b % w, w, h);
    m = t - (3 * w + 3);
    if (m >= 0 && m < p) grad_px(m / w, m % w, w, h);
    o = t - lat;
    if (o >= 0 && o < p) begin
      e.strength = nms_px(o / w, o % w, w, h);
      e.eor = (o % w == w - 1);
      e.eof = (o == p - 1);
      edge_queue.push_back(e);
    end
    if (t + 1 >= p + lat) begin
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // pixel driver
  int in_gap = 0;
  always @(posedge clk) begin
    pix_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) edge_predict(in_tdata, in_tuser);
      if (in_tvalid && !in_tready) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pix_queue.size() > 0) begin
        nb = pix_queue.pop_front();
        in_tdata <= nb.pix;
        in_tuser <= nb.drain;
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // edge monitor
  int out_gap = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    edge_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (edge_queue.size() == 0) begin
          $display("%0t unexpected beat: got %h/%b/%b", $time, out_tdata, out_tlast, out_tuser);
          n_errors++;
        end else begin
          want = edge_queue.pop_front();
          if (want.strength !== out_tdata || want.eor !== out_tlast || want.eof !== out_tuser) begin
            $display("%0t mismatch: exp %h/%b/%b got %h/%b/%b", $time, want.strength,
                     want.eor, want.eof, out_tdata, out_tlast, out_tuser);
            n_errors++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  task automatic drain_all();
    while (pix_queue.size() != 0 || in_tvalid || edge_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FRAME_WIDTH:  begin reg_w = val[10:0]; col_cnt = 0; row_cnt = 0; end
      CFG_FRAME_HEIGHT: begin reg_h = val; col_cnt = 0; row_cnt = 0; end
      CFG_SUPPRESS:     reg_sup = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pix_at(int mode, int x, int y, int a, int b, int c);
    int v;
    case (mode)
      0: v = (x + y >= 8 || (x == 3 && y == 3)) ? 255 : 0;
      1: v = $urandom_range(0, 255);
      2: v = (x * a + y * b > c) ? 250 - c : c;
      3: v = c + x * a + y * b;
      default: v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : c;
    endcase
    return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
  endfunction

  // one frame: w*h pixels with stray drains, then the flush
  task automatic push_frame(int w, int h, int mode, int pause_at, bit hold_flush);
    int a, b, c;
    a = $urandom_range(0, 40) - 20;
    b = $urandom_range(0, 40) - 20;
    c = $urandom_range(0, 250);
    for (int k = 0; k < w * h; k++) begin
      if ($urandom_range(0, 9) == 0)
        pix_queue.push_back('{pix: 8'($urandom), drain: 1'b1});
      pix_queue.push_back('{pix: pix_at(mode, k % w, k / w, a, b, c), drain: 1'b0});
      if (k == pause_at) drain_all();
    end
    for (int k = 0; k < 4 * w + 4; k++)
      pix_queue.push_back('{pix: 8'($urandom), drain: ($urandom_range(0, 4) != 0)});
    if (hold_flush) begin
      while (pix_queue.size() > 2 * w) @(posedge clk);
      hold_req++;
    end
  endtask

  initial begin
    int w, h, n_items;
    for (int i = 0; i < 8 * LINE_LEN; i++) raw_mem[i] = '0;
    for (int i = 0; i < 4 * LINE_LEN; i++) begin
      blur_mem[i] = '0;
      mag_mem[i] = '0;
      dir_mem[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clamped-low size, edge with a spike, suppression on then off
    reg_write(CFG_FRAME_WIDTH, 13'd0);
    reg_write(CFG_FRAME_HEIGHT, 13'd0);
    reg_write(CFG_SUPPRESS, 13'd1);
    push_frame(8, 8, 0, -1, 1'b0);
    drain_all();
    reg_write(CFG_SUPPRESS, 13'h1FFE);
    push_frame(8, 8, 4, -1, 1'b0);
    drain_all();

    // oversized frames, abandoned early
    reg_write(CFG_FRAME_WIDTH, 13'h1FFF);
    reg_write(CFG_FRAME_HEIGHT, 13'h1FFF);
    for (int k = 0; k < 30; k++) pix_queue.push_back('{pix: 8'($urandom), drain: 1'b0});
    drain_all();
    reg_write(CFG_UNUSED, 13'h1FFF);
    reg_write(CFG_FRAME_WIDTH, 13'd1024);
    reg_write(CFG_FRAME_HEIGHT, 13'd4096);
    for (int k = 0; k < 10; k++) pix_queue.push_back('{pix: 8'($urandom), drain: 1'b0});
    drain_all();

    n_items = 0;
    for (int f = 0; n_items < 400; f++) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : 8;
      h = $urandom_range(8, 10);
      steady = ($urandom_range(0, 3) == 0);
      reg_write(CFG_FRAME_WIDTH, 13'(w));
      reg_write(CFG_FRAME_HEIGHT, 13'(h));
      reg_write(CFG_SUPPRESS, 13'($urandom_range(0, 1)));
      push_frame(w, h, $urandom_range(1, 4), (f == 1) ? w * 3 : -1, f == 0);
      if ($urandom_range(0, 1)) begin
        push_frame(w, h, $urandom_range(1, 4), -1, 1'b0);
        n_items += 5 * w + 4 + w * h;
      end
      n_items += 5 * w + 4 + w * h;
      drain_all();
    end
    steady = 1'b0;

    drain_all();
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
